// ===== hdl/mbm_pkg.sv =====
// Package for the bipartite matching block: sizes, register indexes, shared types.
// No dependencies.
package mbm_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int ROW_W = 64;
  localparam logic [0:0] REG_NUM_LEFT  = 1'b0;
  localparam logic [0:0] REG_NUM_RIGHT = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left_index;
    logic [ROW_W-1:0] adjacency_row;
    logic             last_row;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] right_index;
    logic [IDX_W-1:0] left_partner;
    logic             is_matched;
    logic [CNT_W-1:0] match_total;
    logic             last_result;
  } out_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] index;
    logic [CNT_W-1:0] value;
  } cfg_beat_t;
endpackage

// ===== hdl/mbm_if.sv =====
// Valid/ready channel interface carrying one payload beat.
// Depends on mbm_pkg only through the payload type parameter.
interface mbm_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/max_bipartite_matching.sv =====
// Maximum bipartite matching, Kuhn augmenting path with explicit DFS stack.
// Sequence: rows load while in ST_LOAD. After the last row each root runs ROOT,
// FETCH and SCAN, each descend DESC, FETCH and SCAN, each pop POP, FETCH and SCAN;
// a found path walks FLIP down the frames below the top; at the end EMIT sends the results.
// Throughput: one row per cycle; input closed from last row to last result.
// Reset: synchronous active-low rst_n clears control; row memory undefined.
module max_bipartite_matching #(
  parameter int MAX_VERTICES = mbm_pkg::MAX_VERTICES
) (
  input  logic clk,
  input  logic rst_n,
  mbm_if.sink   in_ch,
  mbm_if.source out_ch,
  mbm_if.sink   cfg_ch
);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = IW + 1;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b00000001,
    ST_ROOT  = 8'b00000010,
    ST_FETCH = 8'b00000100,
    ST_SCAN  = 8'b00001000,
    ST_DESC  = 8'b00010000,
    ST_POP   = 8'b00100000,
    ST_FLIP  = 8'b01000000,
    ST_EMIT  = 8'b10000000
  } state_t;

  state_t state_r;
  logic [6:0] num_left_r, num_right_r;
  logic [CW-1:0] nl, nr;

  // row memory, one write port, registered read at the top frame's left vertex
  logic [63:0] rows [MAX_VERTICES];
  logic [63:0] row_q;

  // frames below the top: {left, pick}; the top frame lives in tl/tn/thi
  logic [2*IW-1:0] stk [MAX_VERTICES];
  logic [2*IW-1:0] stk_q;
  logic [IW-1:0]   stk_addr;
  logic            sw_en;
  logic [IW-1:0]   sd_r;    // frames stored below the top

  // partner memory, registered read at pick or at the result index
  logic [IW-1:0] partner [MAX_VERTICES];
  logic [IW-1:0] part_q, part_addr, pw_addr, pw_data;
  logic          pw_en;

  logic [MAX_VERTICES-1:0] pvalid_r, visited_r, in_range;
  logic [CW-1:0] cur_r, count_r, emit_r;
  logic [IW-1:0] tl_r, tn_r;
  logic thi_r; // resume index beyond last lane
  logic found, scan_hit;
  logic [IW-1:0] pick;

  always_comb begin
    nl = (num_left_r == 0) ? CW'(1) :
         (num_left_r > 7'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(num_left_r);
    nr = (num_right_r == 0) ? CW'(1) :
         (num_right_r > 7'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(num_right_r);
    for (int i = 0; i < MAX_VERTICES; i++) in_range[i] = (i < int'(nr));
  end

  mbm_lanes #(.N(MAX_VERTICES)) u_lanes (
    .row(row_q[MAX_VERTICES-1:0]), .visited(visited_r), .in_range(in_range),
    .start(tn_r), .found(found), .pick(pick)
  );

  always_comb begin
    scan_hit = (state_r == ST_SCAN) && found && !thi_r;
    // push the top frame when the picked vertex is taken
    sw_en = scan_hit && pvalid_r[pick];
    // flip walks down one stored frame per cycle, so read one ahead
    stk_addr = (state_r == ST_FLIP) ? sd_r - IW'(2) : sd_r - IW'(1);
    pw_en   = 1'b0;
    pw_addr = pick;
    pw_data = tl_r;
    if (scan_hit && !pvalid_r[pick]) pw_en = 1'b1;
    if (state_r == ST_FLIP && sd_r != '0) begin
      pw_en   = 1'b1;
      pw_addr = stk_q[IW-1:0];
      pw_data = stk_q[2*IW-1:IW];
    end
    part_addr = pick;
    if (state_r == ST_ROOT) part_addr = '0;
    else if (state_r == ST_EMIT)
      part_addr = out_ch.ready ? emit_r[IW-1:0] + IW'(1) : emit_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && (int'(in_ch.data.left_index) < MAX_VERTICES))
      rows[in_ch.data.left_index[IW-1:0]] <= in_ch.data.adjacency_row;
    row_q <= rows[tl_r];
    if (sw_en) stk[sd_r] <= {tl_r, pick};
    stk_q <= stk[stk_addr];
    if (pw_en) partner[pw_addr] <= pw_data;
    part_q <= partner[part_addr];
  end

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == ST_EMIT);
  always_comb begin
    out_ch.data.right_index  = 6'(emit_r);
    out_ch.data.left_partner = pvalid_r[emit_r[IW-1:0]] ? 6'(part_q) : 6'd0;
    out_ch.data.is_matched   = pvalid_r[emit_r[IW-1:0]];
    out_ch.data.match_total  = 7'(count_r);
    out_ch.data.last_result  = (emit_r + CW'(1) == nr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; num_left_r <= 7'd64; num_right_r <= 7'd64;
      sd_r <= '0; cur_r <= '0; count_r <= '0; emit_r <= '0;
      pvalid_r <= '0; visited_r <= '0; tl_r <= '0; tn_r <= '0; thi_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.data.index == 7'(mbm_pkg::REG_NUM_LEFT))  num_left_r  <= cfg_ch.data.value;
        if (cfg_ch.data.index == 7'(mbm_pkg::REG_NUM_RIGHT)) num_right_r <= cfg_ch.data.value;
      end
      unique case (state_r)
        ST_LOAD: if (in_ch.valid && in_ch.data.last_row) begin
          pvalid_r <= '0; count_r <= '0; cur_r <= '0; state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (cur_r == nl) begin
            emit_r <= '0; state_r <= ST_EMIT;
          end else begin
            visited_r <= '0; tl_r <= cur_r[IW-1:0]; tn_r <= '0;
            thi_r <= 1'b0; sd_r <= '0; state_r <= ST_FETCH;
          end
        end
        ST_FETCH: state_r <= ST_SCAN; // row read latency
        ST_SCAN: begin
          if (found && !thi_r) begin
            visited_r[pick] <= 1'b1;
            if (pvalid_r[pick]) begin
              // path depth bounded by left count, so the stack never overflows
              sd_r <= sd_r + IW'(1); state_r <= ST_DESC;
            end else begin
              pvalid_r[pick] <= 1'b1; state_r <= ST_FLIP;
            end
          end else if (sd_r == '0) begin
            cur_r <= cur_r + CW'(1); state_r <= ST_ROOT;
          end else begin
            sd_r <= sd_r - IW'(1); state_r <= ST_POP;
          end
        end
        ST_DESC: begin
          // partner of the picked vertex becomes the new top
          tl_r <= part_q; tn_r <= '0; thi_r <= 1'b0; state_r <= ST_FETCH;
        end
        ST_POP: begin
          tl_r  <= stk_q[2*IW-1:IW];
          tn_r  <= stk_q[IW-1:0] + IW'(1);
          thi_r <= (stk_q[IW-1:0] == '1);
          state_r <= ST_FETCH;
        end
        ST_FLIP: begin
          if (sd_r == '0) begin
            count_r <= count_r + CW'(1); cur_r <= cur_r + CW'(1); state_r <= ST_ROOT;
          end else begin
            sd_r <= sd_r - IW'(1);
          end
        end
        ST_EMIT: if (out_ch.ready) begin
          if (emit_r + CW'(1) == nr) state_r <= ST_LOAD;
          emit_r <= emit_r + CW'(1);
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end
endmodule

// ===== hdl/mbm_lanes.sv =====
// Parallel lane scan: each lane tests one right vertex for an unvisited, in-range
// edge, merge stage picks the lowest lane at or above the resume index.
module mbm_lanes #(
  parameter int N = mbm_pkg::MAX_VERTICES
) (
  input  logic [N-1:0]              row,
  input  logic [N-1:0]              visited,
  input  logic [N-1:0]              in_range,
  input  logic [$clog2(N)-1:0]      start,
  output logic                      found,
  output logic [$clog2(N)-1:0]      pick
);
  logic [N-1:0] cand;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cand[i] = row[i] & ~visited[i] & in_range[i] & (i >= int'(start));
    end
  end
  // priority merge, lowest index wins
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = N-1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        pick  = i[$clog2(N)-1:0];
      end
    end
  end
endmodule

// ===== hdl/mbm_checker.sv =====
// Port-level checks for max_bipartite_matching, attached by bind.
// Depends on no package.
module mbm_checker (
  input logic clk, input logic rst_n,
  input logic in_ready, input logic out_valid, input logic out_ready,
  input logic out_last, input logic [5:0] out_idx
);
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open during output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_idx)) else $error("output dropped");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_idx == $past(out_idx) + 6'd1)
    else $error("index skip");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid) else $error("extra result");
endmodule

bind max_bipartite_matching mbm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_last(out_ch.data.last_result),
  .out_idx(out_ch.data.right_index)
);

// ===== sim/max_bipartite_matching_tb.sv =====
// Self-checking testbench for max_bipartite_matching: loads adjacency matrices
// and checks the per-right-vertex matching beats. Depends on mbm_pkg and mbm_if.
`timescale 1ns / 100ps

module max_bipartite_matching_tb;
  localparam int IDX_W = mbm_pkg::IDX_W;
  localparam int CNT_W = mbm_pkg::CNT_W;
  localparam int ROW_W = mbm_pkg::ROW_W;
  localparam int MAX_VERTICES = mbm_pkg::MAX_VERTICES;

  localparam int HOLD_CYCLES  = 600;
  localparam int WDOG_LIMIT   = 1500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES   = 8;
  localparam logic [CNT_W-1:0] CFG_IDX_UNUSED = 7'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mbm_if #(.payload_t(mbm_pkg::in_beat_t))  in_ch  (clk);
  mbm_if #(.payload_t(mbm_pkg::out_beat_t)) out_ch (clk);
  mbm_if #(.payload_t(mbm_pkg::cfg_beat_t)) cfg_ch (clk);

  max_bipartite_matching dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus rows waiting to go out and matching beats waiting to come back.
  mbm_pkg::in_beat_t  pending_rows[$];
  mbm_pkg::out_beat_t match_beats[$];

  // Predictor state: its own copy of the row store, registers and search.
  logic [ROW_W-1:0] row_store [MAX_VERTICES];
  logic [IDX_W-1:0] owner     [MAX_VERTICES];
  logic             owned     [MAX_VERTICES];
  logic [CNT_W-1:0] left_reg  = 7'd64;
  logic [CNT_W-1:0] right_reg = 7'd64;
  logic             row_loaded [MAX_VERTICES];  // rows queued since reset

  int  mismatches = 0;
  int  sender_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  bit  in_acc = 1'b0;

  function automatic int clamp_count(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_VERTICES) return MAX_VERTICES;
    return int'(v);
  endfunction

  // One augmenting-path search from root with an explicit DFS stack.
  function automatic bit find_path(int root, int nr, ref logic [63:0] seen);
    int fr_left [MAX_VERTICES+1];
    int fr_next [MAX_VERTICES+1];
    int fr_pick [MAX_VERTICES+1];
    int sp, top, x, j;
    bit dove;
    sp = 1;
    fr_left[0] = root;
    fr_next[0] = 0;
    while (sp > 0) begin
      top = sp - 1;
      x = fr_left[top];
      dove = 1'b0;
      for (j = fr_next[top]; j < nr; j++) begin
        if (!row_store[x][j] || seen[j]) continue;
        seen[j] = 1'b1;
        fr_next[top] = j + 1;
        fr_pick[top] = j;
        if (!owned[j]) begin
          // free right vertex: flip every frame on the path
          while (sp > 0) begin
            owner[fr_pick[sp-1]] = IDX_W'(fr_left[sp-1]);
            owned[fr_pick[sp-1]] = 1'b1;
            sp--;
          end
          return 1'b1;
        end
        if (sp <= MAX_VERTICES) begin
          fr_left[sp] = int'(owner[j]);
          fr_next[sp] = 0;
          sp++;
          dove = 1'b1;
          break;
        end
      end
      if (!dove) sp--;
    end
    return 1'b0;
  endfunction

  // Store the row; on the last row run the matching and queue its beats.
  function automatic void predict_matching(mbm_pkg::in_beat_t b);
    int nl, nr, total;
    logic [63:0] seen;
    mbm_pkg::out_beat_t r;
    row_store[b.left_index] = b.adjacency_row;
    if (!b.last_row) return;
    nl = clamp_count(left_reg);
    nr = clamp_count(right_reg);
    total = 0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      owned[j] = 1'b0;
      owner[j] = '0;
    end
    for (int i = 0; i < nl; i++) begin
      seen = '0;
      if (find_path(i, nr, seen)) total++;
    end
    for (int j = 0; j < nr; j++) begin
      r.right_index  = IDX_W'(j);
      r.left_partner = owned[j] ? owner[j] : '0;
      r.is_matched   = owned[j];
      r.match_total  = CNT_W'(total);
      r.last_result  = (j == nr - 1);
      match_beats.push_back(r);
    end
  endfunction

  // Sender: holds a row until taken, idles at random between rows.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_acc) void'(pending_rows.pop_front());
      if (in_ch.valid && !in_acc) begin
        in_ch.valid <= 1'b1;
      end else if (pending_rows.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_rows[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here apart from the sender, which keeps its row waiting.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts on every accepted row, checks every accepted result beat.
  always @(posedge clk) begin
    mbm_pkg::out_beat_t want, got;
    in_acc <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) predict_matching(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (match_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
      end else begin
        want = match_beats.pop_front();
        if (got.right_index !== want.right_index || got.left_partner !== want.left_partner ||
            got.is_matched !== want.is_matched || got.match_total !== want.match_total ||
            got.last_result !== want.last_result) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog: too long without any beat on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic write_reg(logic [CNT_W-1:0] idx, logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CNT_W'(mbm_pkg::REG_NUM_LEFT)) left_reg = val;
    else if (idx == CNT_W'(mbm_pkg::REG_NUM_RIGHT)) right_reg = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void push_row(int idx, logic [ROW_W-1:0] row, bit last);
    mbm_pkg::in_beat_t b;
    b.left_index    = IDX_W'(idx);
    b.adjacency_row = row;
    b.last_row      = last;
    pending_rows.push_back(b);
    row_loaded[idx] = 1'b1;
  endfunction

  task automatic wait_idle();
    wait (pending_rows.size() == 0 && match_beats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ROW_W-1:0] rand_row(int nl);
    logic [ROW_W-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    if (nl > 16) return a & b & c;   // keep big searches short
    case ($urandom_range(3))
      0: return a;
      1: return a & b;
      2: return a & b & c;
      default: return ROW_W'(1) << $urandom_range(63);
    endcase
  endfunction

  // One matrix: rows in shuffled order with noise, the last one flagged, or at times
  // one rewritten row over the stored ones. Returns the number of beats queued.
  function automatic int queue_matrix();
    int nl, cnt;
    int order[$];
    bit all_loaded;
    nl = clamp_count(left_reg);
    all_loaded = 1'b1;
    for (int i = 0; i < nl; i++) all_loaded &= row_loaded[i];
    if (all_loaded && $urandom_range(4) == 0) begin
      // reuse stored rows, rewrite just one
      push_row($urandom_range(nl - 1), rand_row(nl), 1'b1);
      return 1;
    end
    for (int i = 0; i < nl; i++) order.push_back(i);
    order.shuffle();
    cnt = 0;
    foreach (order[k]) begin
      if (nl < MAX_VERTICES && $urandom_range(5) == 0) begin
        push_row($urandom_range(MAX_VERTICES - 1, nl), {$urandom, $urandom}, 1'b0);
        cnt++;
      end
      push_row(order[k], rand_row(nl), k == order.size() - 1);
      cnt++;
    end
    return cnt;
  endfunction

  initial begin
    int sent, lv, rv;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    foreach (row_loaded[i]) row_loaded[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero registers clamp to one vertex each.
    write_reg(CNT_W'(mbm_pkg::REG_NUM_LEFT), 7'd0);
    write_reg(CNT_W'(mbm_pkg::REG_NUM_RIGHT), 7'd0);
    push_row(0, '1, 1'b1);
    push_row(0, '0, 1'b1);
    wait_idle();
    // Three by three needing an augmenting path, a noise row at the top
    // index, edges past num_right, and an index outside the register list.
    write_reg(CNT_W'(mbm_pkg::REG_NUM_LEFT), 7'd3);
    write_reg(CNT_W'(mbm_pkg::REG_NUM_RIGHT), 7'd3);
    write_reg(CFG_IDX_UNUSED, 7'd1);
    push_row(0, 64'b011, 1'b0);
    push_row(1, 64'b001, 1'b0);
    push_row(63, '1, 1'b0);
    push_row(2, 64'b110, 1'b1);
    push_row(2, '1, 1'b1);
    push_row(1, '0, 1'b1);
    push_row(0, 64'h8000_0000_0000_0000, 1'b1);
    wait_idle();

    // Random phases: extremes of the registers first, then small sizes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      case (p)
        0: begin lv = 64;  rv = 64;  end
        1: begin lv = 127; rv = 1;   end
        2: begin lv = 1;   rv = 127; end
        3: begin lv = 64;  rv = 2;   end
        default: begin lv = $urandom_range(8); rv = $urandom_range(8); end
      endcase
      write_reg(CNT_W'(mbm_pkg::REG_NUM_LEFT), CNT_W'(lv));
      write_reg(CNT_W'(mbm_pkg::REG_NUM_RIGHT), CNT_W'(rv));
      if (p == 4) hold_req = 1'b1;  // block fills and stalls its input
      sent = 0;
      while (sent < 20) sent += queue_matrix();
      wait_idle();
    end

    if (match_beats.size() == 0 && mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
